// ----- rtl/spq_pkg.sv -----
// spq_pkg: shared types and codes for the sorted priority queue
// item structs, command and status codes, controller state encoding
// no dependencies
`default_nettype none

package spq_pkg;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_DUMP   = 1'b1;

    typedef enum logic [1:0] {
        STATUS_DATA   = 2'd0,
        STATUS_ACCEPT = 2'd1,
        STATUS_FULL   = 2'd2,
        STATUS_EMPTY  = 2'd3
    } spq_status_t;

    typedef struct packed {
        logic               cmd;
        logic [7:0]         entry_char;
        logic signed [15:0] entry_priority;
    } spq_req_t;

    typedef struct packed {
        logic [7:0]         out_char;
        logic signed [15:0] out_priority;
        logic [1:0]         status;
        logic               last;
    } spq_rsp_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_PLACE,
        ST_DUMP,
        ST_RESP
    } spq_state_t;

endpackage

`default_nettype wire

// ----- rtl/spq_ram.sv -----
// spq_ram: generic simple dual-port ram, one write and one registered read port
// depends on nothing
`default_nettype none

module spq_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ----- rtl/sorted_priority_queue_unit.sv -----
// sorted priority queue: entries kept in ascending priority order in one ram
// insert: full or empty table goes straight to the response state after accept; otherwise the
//   scan takes one read-compare-write step per stored entry of greater priority, one to place
// dump: entry 0 is read on accept and registered as the first result, then one per cycle while rsp_ready holds
// one item at a time; reset clears state and entry count, ram contents need no clearing
// depends on spq_pkg, spq_ram
`default_nettype none

module sorted_priority_queue_unit #(
    parameter int CAPACITY      = 32,
    parameter int PRIORITY_BITS = 16
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             req_valid,
    output logic                  req_ready,
    input  wire spq_pkg::spq_req_t req,
    output logic                  rsp_valid,
    input  wire logic             rsp_ready,
    output spq_pkg::spq_rsp_t     rsp
);

    import spq_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int EW = 8 + PRIORITY_BITS;

    spq_state_t state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [AW-1:0] pos_reg, pos_next;
    logic [7:0] new_char_reg, new_char_next;
    logic signed [PRIORITY_BITS-1:0] new_prio_reg, new_prio_next;
    spq_status_t status_reg, status_next;
    spq_rsp_t rsp_reg, rsp_next;
    logic rsp_valid_reg, rsp_valid_next;

    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [EW-1:0] wr_data;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [EW-1:0] rd_data;

    logic signed [PRIORITY_BITS-1:0] sat_prio;
    logic signed [PRIORITY_BITS-1:0] rd_prio;
    logic [7:0] rd_char;
    logic signed [15:0] rd_prio_out;
    logic req_fire;
    logic rsp_free;
    logic shift;
    logic at_last;

    spq_ram #(
        .WIDTH(EW),
        .DEPTH(CAPACITY)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // clamp incoming priority into the stored width, and widen it back for output
    generate
        if (PRIORITY_BITS >= 16)
        begin : g_wide
            assign sat_prio    = PRIORITY_BITS'(req.entry_priority);
            assign rd_prio_out = rd_prio[15:0];
        end
        else
        begin : g_narrow
            logic over;
            assign over = req.entry_priority[15:PRIORITY_BITS-1]
                          != {(17 - PRIORITY_BITS){req.entry_priority[15]}};
            assign sat_prio = !over ? req.entry_priority[PRIORITY_BITS-1:0] :
                              req.entry_priority[15] ? {1'b1, {(PRIORITY_BITS-1){1'b0}}} :
                                                       {1'b0, {(PRIORITY_BITS-1){1'b1}}};
            assign rd_prio_out = 16'(rd_prio);
        end
    endgenerate

    assign rd_prio   = rd_data[PRIORITY_BITS-1:0];
    assign rd_char   = rd_data[EW-1:PRIORITY_BITS];
    assign req_ready = (state_reg == ST_IDLE);
    assign req_fire  = req_valid && req_ready;
    assign rsp_free  = !rsp_valid_reg || rsp_ready;
    assign shift     = rd_prio > new_prio_reg;
    assign at_last   = (CW'(pos_reg) == count_reg - CW'(1));
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_fire)
                begin
                    if (req.cmd == CMD_INSERT)
                    begin
                        if (count_reg == CW'(CAPACITY) || count_reg == '0)
                            state_next = ST_RESP;
                        else
                            state_next = ST_SCAN;
                    end
                    else if (count_reg == '0)
                        state_next = ST_RESP;
                    else
                        state_next = ST_DUMP;
                end
            end
            ST_SCAN:
            begin
                if (shift && pos_reg == '0)
                    state_next = ST_PLACE;
                else if (!shift)
                    state_next = ST_RESP;
            end
            ST_PLACE:
                state_next = ST_RESP;
            ST_DUMP:
            begin
                if (rsp_free && at_last)
                    state_next = ST_IDLE;
            end
            ST_RESP:
            begin
                if (rsp_free)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        count_next     = count_reg;
        pos_next       = pos_reg;
        new_char_next  = new_char_reg;
        new_prio_next  = new_prio_reg;
        status_next    = status_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        wr_en          = 1'b0;
        wr_addr        = '0;
        wr_data        = {new_char_reg, new_prio_reg};
        rd_en          = 1'b0;
        rd_addr        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_fire)
                begin
                    new_char_next = req.entry_char;
                    new_prio_next = sat_prio;
                    if (req.cmd == CMD_INSERT)
                    begin
                        if (count_reg == CW'(CAPACITY))
                            status_next = STATUS_FULL;
                        else if (count_reg == '0)
                        begin
                            wr_en       = 1'b1;
                            wr_data     = {req.entry_char, sat_prio};
                            count_next  = count_reg + CW'(1);
                            status_next = STATUS_ACCEPT;
                        end
                        else
                        begin
                            // scan downward from the tail entry
                            rd_en    = 1'b1;
                            rd_addr  = AW'(count_reg - CW'(1));
                            pos_next = AW'(count_reg - CW'(1));
                        end
                    end
                    else if (count_reg == '0)
                        status_next = STATUS_EMPTY;
                    else
                    begin
                        rd_en    = 1'b1;
                        rd_addr  = '0;
                        pos_next = '0;
                    end
                end
            end
            ST_SCAN:
            begin
                // entry at pos is on the ram output; read pos-1 (while shifting above entry 0) while writing pos+1
                wr_en   = 1'b1;
                wr_addr = pos_reg + AW'(1);
                if (shift)
                begin
                    wr_data = rd_data;
                    if (pos_reg != '0)
                    begin
                        rd_en    = 1'b1;
                        rd_addr  = pos_reg - AW'(1);
                        pos_next = pos_reg - AW'(1);
                    end
                end
                else
                begin
                    count_next  = count_reg + CW'(1);
                    status_next = STATUS_ACCEPT;
                end
            end
            ST_PLACE:
            begin
                wr_en       = 1'b1;
                wr_addr     = '0;
                count_next  = count_reg + CW'(1);
                status_next = STATUS_ACCEPT;
            end
            ST_DUMP:
            begin
                if (rsp_free)
                begin
                    rsp_valid_next        = 1'b1;
                    rsp_next.out_char     = rd_char;
                    rsp_next.out_priority = rd_prio_out;
                    rsp_next.status       = STATUS_DATA;
                    rsp_next.last         = at_last;
                    if (!at_last)
                    begin
                        rd_en    = 1'b1;
                        rd_addr  = pos_reg + AW'(1);
                        pos_next = pos_reg + AW'(1);
                    end
                end
            end
            ST_RESP:
            begin
                if (rsp_free)
                begin
                    rsp_valid_next        = 1'b1;
                    rsp_next.out_char     = '0;
                    rsp_next.out_priority = '0;
                    rsp_next.status       = status_reg;
                    rsp_next.last         = 1'b1;
                end
            end
            default:
            begin
                rsp_valid_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg      <= pos_next;
        new_char_reg <= new_char_next;
        new_prio_reg <= new_prio_next;
        status_reg   <= status_next;
        rsp_reg      <= rsp_next;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("entry count beyond capacity");

    a_no_write_in_dump: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DUMP || state_reg == ST_RESP) |-> !wr_en)
        else $error("ram written outside an insert");

    a_rw_distinct: assert property (@(posedge clk) disable iff (!rst_n)
        (rd_en && wr_en) |-> (rd_addr != wr_addr))
        else $error("read and write hit the same entry");

    a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (CW'(wr_addr) <= count_reg) && (count_reg < CW'(CAPACITY)))
        else $error("write beyond stored entries");

    a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (req_fire && req.cmd == CMD_INSERT && count_reg == CW'(CAPACITY))
        |=> (state_reg == ST_RESP && status_reg == STATUS_FULL && $stable(count_reg)))
        else $error("insert into full table not dropped");

endmodule

`default_nettype wire
